// ===== hdl/large_page_directory_table_macros.svh =====
// ----------------------------------------------------------------------------
// large_page_directory_table_macros.svh
// Assertion macros shared by the directory table RTL.
// ----------------------------------------------------------------------------
`ifndef LARGE_PAGE_DIRECTORY_TABLE_MACROS_SVH
`define LARGE_PAGE_DIRECTORY_TABLE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LPDT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check an implication whose consequent must hold in the next cycle, outside reset.
`define LPDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lpdt_pkg.sv =====
// ----------------------------------------------------------------------------
// lpdt_pkg
// Types and constants of the large-page directory table.
// ----------------------------------------------------------------------------
package lpdt_pkg;

    localparam int ENTRY_COUNT = 1024;
    localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int ADDR_W      = 32;
    localparam int FRAME_SHIFT = 22;
    localparam int FRAME_W     = ADDR_W - FRAME_SHIFT;
    localparam int FLAGS_W     = 16;

    localparam logic [ADDR_W-1:0] MISS_ADDRESS = 32'h0000_0068;

    typedef enum logic [1:0] {
        OP_MAP       = 2'd0,
        OP_UNMAP     = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_REVERSE   = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode             opcode;
        logic [ADDR_W-1:0]   address;
        logic [ADDR_W-1:0]   phys_base;
        logic [FLAGS_W-1:0]  entry_flags;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]   result_address;
        logic                found;
    } t_out_item;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame;
        logic [FLAGS_W-1:0]  flags;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCAN
    } t_state;

endpackage

// ===== hdl/large_page_directory_table.sv =====
// ----------------------------------------------------------------------------
// large_page_directory_table
// Directory of 4 MB page entries in one synchronous RAM: map, unmap,
// translate and reverse search by frame.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+----------------------------
//   input   | i_valid / o_stall  | i_item (t_in_item)
//   output  | o_valid / i_stall  | o_item (t_out_item)
//
// Map and unmap register their result when accepted; translate reads the
// RAM first and registers its result from S_READ. Reverse search reads
// one entry per cycle through the single RAM read port, stopping at the
// first frame match. After reset a clearing pass writes zero to all
// ENTRY_COUNT entries, one per cycle; o_stall stays high until it ends.
// One item is in flight at a time; a new item enters while the previous
// result is being taken.
// ----------------------------------------------------------------------------
`include "large_page_directory_table_macros.svh"

module large_page_directory_table
    import lpdt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    t_entry r_mem [ENTRY_COUNT];

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_in_range;
    t_entry             r_rd;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               accept;
    logic               out_free;
    logic [FRAME_W-1:0] in_idx;
    logic               in_range;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;
    logic               load_out;
    t_out_item          out_d;

    assign in_idx   = i_item.address[ADDR_W-1:FRAME_SHIFT];
    assign in_range = (32'(in_idx) < 32'(ENTRY_COUNT));
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || !out_free;
    assign accept   = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_item   = r_out;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        rd_addr  = r_idx + 1'b1;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_data  = '0;
        load_out = 1'b0;
        out_d    = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == IDX_W'(ENTRY_COUNT - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                rd_addr = in_idx[IDX_W-1:0];
                wr_addr = in_idx[IDX_W-1:0];
                if (accept) begin
                    unique case (i_item.opcode)
                        OP_MAP: begin
                            wr_en         = in_range;
                            wr_data.frame = i_item.phys_base[ADDR_W-1:FRAME_SHIFT];
                            wr_data.flags = i_item.entry_flags;
                            load_out      = 1'b1;
                            out_d.found   = 1'b1;
                        end
                        OP_UNMAP: begin
                            wr_en       = in_range;
                            load_out    = 1'b1;
                            out_d.found = 1'b1;
                        end
                        OP_TRANSLATE: begin
                            n_state = S_READ;
                        end
                        OP_REVERSE: begin
                            rd_addr = '0;
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end
            S_READ: begin
                load_out                         = 1'b1;
                out_d.found                      = 1'b1;
                out_d.result_address[FRAME_SHIFT-1:0] = r_addr[FRAME_SHIFT-1:0];
                out_d.result_address[ADDR_W-1:FRAME_SHIFT] =
                    r_in_range ? r_rd.frame : '0;
                n_state                          = S_IDLE;
            end
            S_SCAN: begin
                priority if (r_rd.frame == r_addr[ADDR_W-1:FRAME_SHIFT]) begin
                    load_out    = 1'b1;
                    out_d.found = 1'b1;
                    out_d.result_address[FRAME_SHIFT-1:0] = r_addr[FRAME_SHIFT-1:0];
                    out_d.result_address[ADDR_W-1:FRAME_SHIFT] = FRAME_W'(r_idx);
                    n_state     = S_IDLE;
                end else if (r_idx == IDX_W'(ENTRY_COUNT - 1)) begin
                    load_out             = 1'b1;
                    out_d.found          = 1'b0;
                    out_d.result_address = MISS_ADDRESS;
                    n_state              = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr     <= i_item.address;
            r_in_range <= in_range;
        end
        if (load_out) begin
            r_out <= out_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    `LPDT_ASSERT(a_busy_no_result, ((r_state == S_SCAN || r_state == S_READ) |-> !r_out_valid), "result held during active work")
    `LPDT_ASSERT(a_miss_code, ((o_valid && !o_item.found) |-> (o_item.result_address == MISS_ADDRESS)), "miss without miss address")
    `LPDT_ASSERT_NEXT(a_map_done, (accept && (i_item.opcode == OP_MAP || i_item.opcode == OP_UNMAP)), (o_valid && o_item.found && r_state == S_IDLE), "map or unmap result missing")
    `LPDT_ASSERT_NEXT(a_translate_read, (accept && i_item.opcode == OP_TRANSLATE), (r_state == S_READ), "translate did not enter read")

endmodule
